// File: rtl/lru_page_replacement_defines.svh
// Assertion macros used by the controller RTL of the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define LRU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

    localparam int NUM_FRAMES = 8;
    localparam int PAGE_WIDTH = 8;

    localparam int CFG_W     = 4;
    localparam int FILL_W    = $clog2(NUM_FRAMES + 1);
    localparam int CAP_W     = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int FAULT_W   = 16;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(3);
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming page
        logic update;  // run the stack update and load the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: rtl/lru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lru_page_replacement_defines.svh"

module lru_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output lru_pkg::t_dp_cmd     o_cmd
);
    import lru_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // The result register can take a new word when empty or being drained.
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_BUSY: begin
                o_cmd.update = out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `LRU_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, r_out_valid && !i_m_tready,
        r_out_valid, "stalled result word was dropped")
    `LRU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        (r_state == ST_BUSY) && !o_s_tready, "controller did not go busy after accept")
    `LRU_ASSERT_NEXT(a_update_valid, i_clk, i_rst_n, o_cmd.update,
        r_out_valid, "update did not produce a result word")
    `LRU_ASSERT_IMPL(a_cmd_excl, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.load, o_cmd.update}), "load and update issued together")

endmodule

`default_nettype wire

// File: rtl/lru_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lru_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lru_pkg::t_dp_cmd               i_cmd,
    input  wire logic [lru_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [lru_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic      [lru_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import lru_pkg::*;

    logic [PAGE_WIDTH-1:0] r_page;
    logic [PAGE_WIDTH-1:0] r_stack [NUM_FRAMES];
    logic [PAGE_WIDTH-1:0] n_stack [NUM_FRAMES];
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    logic [FAULT_W-1:0]    r_fault_cnt;
    logic [FAULT_W-1:0]    n_fault_cnt;
    logic [CFG_W-1:0]      r_cfg;

    logic                  r_out_fault;
    logic                  r_out_ev_valid;
    logic [7:0]            r_out_ev_page;
    logic [FAULT_W-1:0]    r_out_total;
    logic [3:0]            r_out_count;

    logic [CAP_W-1:0]      cfg_wide;
    logic [CAP_W-1:0]      cap;
    logic                  full;
    logic [NUM_FRAMES-1:0] match;
    logic                  hit;
    logic [FILL_W-1:0]     hit_pos;
    logic                  evict;
    logic                  shift;
    logic [FILL_W-1:0]     shift_from;
    logic [FILL_W-1:0]     last_slot;

    // Effective frame count: zero acts as one, large values clip to the depth.
    always_comb begin
        cfg_wide = CAP_W'(r_cfg);
        if (cfg_wide == '0) begin
            cap = CAP_W'(1);
        end else if (cfg_wide > CAP_W'(NUM_FRAMES)) begin
            cap = CAP_W'(NUM_FRAMES);
        end else begin
            cap = cfg_wide;
        end
    end

    assign full = CAP_W'(r_fill) >= cap;

    // One comparator per slot; the lowest matching resident slot wins.
    always_comb begin
        hit_pos = '0;
        for (int k = 0; k < NUM_FRAMES; k++) begin
            match[k] = (r_stack[k] == r_page) && (FILL_W'(k) < r_fill);
        end
        for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
            if (match[k]) begin
                hit_pos = FILL_W'(k);
            end
        end
    end

    assign hit        = |match;
    assign evict      = !hit && full;
    assign shift      = hit || evict;
    assign shift_from = hit ? hit_pos : '0;
    assign last_slot  = r_fill - FILL_W'(1);

    always_comb begin
        for (int k = 0; k < NUM_FRAMES; k++) begin
            n_stack[k] = r_stack[k];
            if (shift) begin
                if (FILL_W'(k) == last_slot) begin
                    n_stack[k] = r_page;
                end else if (k < NUM_FRAMES - 1) begin
                    if ((FILL_W'(k) >= shift_from) && (FILL_W'(k + 1) < r_fill)) begin
                        n_stack[k] = r_stack[k + 1];
                    end
                end
            end else if (FILL_W'(k) == r_fill) begin
                n_stack[k] = r_page;
            end
        end
    end

    always_comb begin
        n_fill      = r_fill;
        n_fault_cnt = r_fault_cnt;
        if (!hit) begin
            if (r_fault_cnt != FAULT_MAX) begin
                n_fault_cnt = r_fault_cnt + FAULT_W'(1);
            end
            if (!full) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_fault_cnt <= '0;
            r_cfg       <= CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                r_fill      <= n_fill;
                r_fault_cnt <= n_fault_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= PAGE_WIDTH'(i_s_tdata);
        end
        if (i_cmd.update) begin
            for (int k = 0; k < NUM_FRAMES; k++) begin
                r_stack[k] <= n_stack[k];
            end
            r_out_fault    <= !hit;
            r_out_ev_valid <= evict;
            r_out_ev_page  <= evict ? 8'(r_stack[0]) : 8'd0;
            r_out_total    <= n_fault_cnt;
            r_out_count    <= 4'(n_fill);
        end
    end

    assign o_m_tdata = {2'b00, r_out_count, r_out_total, r_out_ev_page,
                        r_out_ev_valid, r_out_fault};

endmodule

`default_nettype wire

// File: rtl/lru_page_replacement.sv
// Each page word is captured by the controller, then a stack update loads its
// result word; a new page word is not taken until that update is done, and a
// stalled result delays the update.
// Reset (i_rst_n low, synchronous) empties the stack, zeroes the fault total,
// sets the frame count register to 3 and clears the result valid; the input
// ready is high from the first reset edge on, since the controller is idle.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Page reference stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [7:0] page
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,    // [0] fault, [1] evicted_valid,
                                           // [9:2] evicted_page, [25:10] fault_total,
                                           // [29:26] resident_count, [31:30] zero
    // Frame count register.
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata   // frames_in_use
);
    import lru_pkg::*;

    // The controller sequences each page word: it captures the word while
    // idle, then issues one update once the result register is free. The
    // datapath holds the recency stack as a row of slot registers, each with
    // its own comparator, so the hit search and the gap-closing shift finish
    // in the update cycle. Slot zero holds the least recently used page.
    t_dp_cmd cmd;

    lru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // The datapath also owns the frame count register, the fill count and the
    // saturating fault total, and registers each result word for the output.
    lru_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire
